### design/cbsf_pkg.sv
`default_nettype none

package cbsf_pkg;

   // Line codes
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_XOR   = 8'h20;
   // x^8 + x^4 + x^3 + x + 1, top bit implied
   localparam logic [7:0] CRC_POLY  = 8'h1B;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One classified input word, as handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] crc;
      logic [7:0] trailer;
      logic       start;
      logic       last;
   } entry_type;

   // Output byte slots of one entry
   typedef enum logic [5:0] {
      ST_FLAG     = 6'b000001,
      ST_DATA_ESC = 6'b000010,
      ST_DATA     = 6'b000100,
      ST_CRC_ESC  = 6'b001000,
      ST_CRC      = 6'b010000,
      ST_TRAIL    = 6'b100000
   } step_type;

   // MSB-first CRC-8 over one byte
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // Bytes that must go out behind an escape
   function automatic logic is_special(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

endpackage

`default_nettype wire

### design/cbsf_front.sv
`default_nettype none

module cbsf_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_frame_end,
   input  wire logic [7:0]          req_trailer_byte,
   input  wire logic                q_full,
   output logic                     req_stall,
   output logic                     push,
   output cbsf_pkg::entry_type      push_entry
);

   logic [7:0] crc_ff, crc_in;
   logic       in_frame_ff, in_frame_in;
   logic [7:0] crc_base;
   logic [7:0] crc_next;

   // Stall only on a full queue
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // Restart the CRC at frame start and fold in this word
   assign crc_base = in_frame_ff ? crc_ff : 8'h00;
   assign crc_next = cbsf_pkg::crc8_update(crc_base, req_data_byte);

   // Classify the word for the back end
   always_comb begin
      push_entry.data    = req_data_byte;
      push_entry.crc     = crc_next;
      push_entry.trailer = req_trailer_byte;
      push_entry.start   = !in_frame_ff;
      push_entry.last    = req_frame_end;
   end

   // Advance frame state on each accepted word
   always_comb begin
      crc_in      = crc_ff;
      in_frame_in = in_frame_ff;
      if (push) begin
         if (req_frame_end) begin
            crc_in      = 8'h00;
            in_frame_in = 1'b0;
         end else begin
            crc_in      = crc_next;
            in_frame_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= 8'h00;
         in_frame_ff <= 1'b0;
      end else begin
         crc_ff      <= crc_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

`default_nettype wire

### design/cbsf_queue.sv
`default_nettype none

module cbsf_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cbsf_pkg::entry_type push_entry,
   input  wire logic                pop,
   output logic                     full,
   output logic                     nonempty,
   output cbsf_pkg::entry_type      head
);

   localparam int AW = cbsf_pkg::QUEUE_AW;

   cbsf_pkg::entry_type mem_ff [cbsf_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   assign full     = (count_ff == (AW+1)'(cbsf_pkg::QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(cbsf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(cbsf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### design/cbsf_back.sv
`default_nettype none

module cbsf_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_nonempty,
   input  wire cbsf_pkg::entry_type head,
   output logic                     pop,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_out_last
);

   cbsf_pkg::entry_type cur_ff, cur_in;
   logic                cur_valid_ff, cur_valid_in;
   cbsf_pkg::step_type  step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;

   cbsf_pkg::step_type  step_nxt;
   logic [7:0]          byte_now;
   logic                last_now;
   logic                done_now;
   logic                advance;

   function automatic cbsf_pkg::step_type data_first(input logic [7:0] d);
      return cbsf_pkg::is_special(d) ? cbsf_pkg::ST_DATA_ESC : cbsf_pkg::ST_DATA;
   endfunction

   function automatic cbsf_pkg::step_type crc_first(input logic [7:0] c);
      return cbsf_pkg::is_special(c) ? cbsf_pkg::ST_CRC_ESC : cbsf_pkg::ST_CRC;
   endfunction

   // Pick the byte for the current slot and the slot after it
   always_comb begin
      byte_now = 8'h00;
      last_now = 1'b0;
      done_now = 1'b0;
      step_nxt = step_ff;
      case (step_ff)
         cbsf_pkg::ST_FLAG: begin
            byte_now = cbsf_pkg::FLAG_BYTE;
            step_nxt = data_first(cur_ff.data);
         end
         cbsf_pkg::ST_DATA_ESC: begin
            byte_now = cbsf_pkg::ESC_BYTE;
            step_nxt = cbsf_pkg::ST_DATA;
         end
         cbsf_pkg::ST_DATA: begin
            byte_now = cbsf_pkg::is_special(cur_ff.data) ?
                       (cur_ff.data ^ cbsf_pkg::ESC_XOR) : cur_ff.data;
            if (cur_ff.last) begin
               step_nxt = crc_first(cur_ff.crc);
            end else begin
               done_now = 1'b1;
            end
         end
         cbsf_pkg::ST_CRC_ESC: begin
            byte_now = cbsf_pkg::ESC_BYTE;
            step_nxt = cbsf_pkg::ST_CRC;
         end
         cbsf_pkg::ST_CRC: begin
            byte_now = cbsf_pkg::is_special(cur_ff.crc) ?
                       (cur_ff.crc ^ cbsf_pkg::ESC_XOR) : cur_ff.crc;
            step_nxt = cbsf_pkg::ST_TRAIL;
         end
         cbsf_pkg::ST_TRAIL: begin
            byte_now = cur_ff.trailer;
            last_now = 1'b1;
            done_now = 1'b1;
         end
         default: begin
            done_now = 1'b1;
         end
      endcase
   end

   // Emit whenever the output register is free or being taken
   assign advance = cur_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop     = q_nonempty && (!cur_valid_ff || (advance && done_now));

   // Load the next entry or step through the current one
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (pop) begin
         cur_in       = head;
         cur_valid_in = 1'b1;
         step_in      = head.start ? cbsf_pkg::ST_FLAG : data_first(head.data);
      end else if (advance && done_now) begin
         cur_valid_in = 1'b0;
      end else if (advance) begin
         step_in = step_nxt;
      end
   end

   // Hold the output word while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = byte_now;
         rsp_last_in  = last_now;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= cbsf_pkg::ST_FLAG;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   // Slot code stays one-hot
   a_step_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(step_ff))
      else $error("back end slot code not one-hot");

   // Trailer slot only on a frame-ending entry
   a_trail_last: assert property (@(posedge clock) disable iff (reset)
      (advance && step_ff == cbsf_pkg::ST_TRAIL) |-> cur_ff.last)
      else $error("trailer emitted for entry without frame end");

   // An escape prefix is followed at once by its escaped byte
   a_escape_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && rsp_byte_ff == cbsf_pkg::ESC_BYTE && !rsp_last_ff)
      |=> (rsp_valid_ff && (rsp_byte_ff == 8'h5D || rsp_byte_ff == 8'h5E)))
      else $error("escape prefix not followed by escaped byte");

endmodule

`default_nettype wire

### design/crc8_byte_stuffing_framer.sv
// Path: an accepted word passes the queue, the current-entry register and the
// output register. Throughput: one line byte per cycle from the back end sequencer
// while rsp_stall is low; a word yields 1 to 6 bytes (flag, escape prefixes, CRC
// and trailer each add one). A four-word queue lets input run ahead of the line.
// Reset: synchronous, active high; clears CRC, frame state, queue and output valid.
`default_nettype none

module crc8_byte_stuffing_framer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_frame_end,
   input  wire logic [7:0] req_trailer_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);

   logic                q_full;
   logic                q_nonempty;
   logic                push;
   logic                pop;
   cbsf_pkg::entry_type push_entry;
   cbsf_pkg::entry_type head;

   cbsf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_data_byte    (req_data_byte),
      .req_frame_end    (req_frame_end),
      .req_trailer_byte (req_trailer_byte),
      .q_full           (q_full),
      .req_stall        (req_stall),
      .push             (push),
      .push_entry       (push_entry)
   );

   cbsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .nonempty   (q_nonempty),
      .head       (head)
   );

   cbsf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_nonempty   (q_nonempty),
      .head         (head),
      .pop          (pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire
